@@ design/mwo_pkg.sv @@
package mwo_pkg;

    localparam int DEF_SINE_TABLE_BITS = 10;
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_COUNT_BITS      = 24;

    localparam int SAMPLE_BITS   = 16;
    localparam int WAVE_BITS     = 2;
    localparam int STEP_BITS     = 32;
    localparam int LENGTH_BITS   = 24;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam int unsigned AMP         = 30000;
    localparam int unsigned HALF_PI_Q30 = 1686629713;

    typedef enum logic [WAVE_BITS-1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_SQUARE = 2'd3
    } t_wave;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WAVEFORM    = 2'd0,
        CFG_PHASE_STEP  = 2'd1,
        CFG_TONE_LENGTH = 2'd2
    } t_cfg_idx;

    // Quarter-wave sine entry j, scaled to the amplitude, from a Q30 Taylor series.
    function automatic logic [SAMPLE_BITS-1:0] quarter_entry(int unsigned tb, int unsigned j);
        logic [63:0]        x;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic [63:0]        p;
        x = (64'(HALF_PI_Q30) * 64'(j) + (64'd1 << (tb - 3))) >> (tb - 2);
        s = signed'(x);
        t = x;
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'd6;
        s = s - signed'(t);
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'd20;
        s = s + signed'(t);
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'd42;
        s = s - signed'(t);
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'd72;
        s = s + signed'(t);
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'd110;
        s = s - signed'(t);
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'd156;
        s = s + signed'(t);
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'd210;
        s = s - signed'(t);
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'd272;
        s = s + signed'(t);
        if (s < 0) begin
            s = 64'sd0;
        end
        p = (64'(s) * 64'(AMP) + (64'd1 << 29)) >> 30;
        return p[SAMPLE_BITS-1:0];
    endfunction

endpackage

@@ design/mwo_req_if.sv @@
interface mwo_req_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink   (input valid, input start_req, output ready);
endinterface

@@ design/mwo_smp_if.sv @@
interface mwo_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               active;
    logic               last;

    modport source (output valid, output sample, output active, output last, input ready);
    modport sink   (input valid, input sample, input active, input last, output ready);
endinterface

@@ design/mwo_wave.sv @@
module mwo_wave #(
    parameter int SINE_TABLE_BITS = mwo_pkg::DEF_SINE_TABLE_BITS,
    parameter int PHASE_BITS      = mwo_pkg::DEF_PHASE_BITS
) (
    input  mwo_pkg::t_wave                          i_wave,
    input  logic [PHASE_BITS-1:0]                   i_phase,
    output logic signed [mwo_pkg::SAMPLE_BITS-1:0]  o_sample
);
    import mwo_pkg::*;

    localparam int TB     = SINE_TABLE_BITS;
    localparam int QTR_N  = 1 << (TB - 2);
    localparam int IDX_W  = TB - 1;
    localparam int MW     = PHASE_BITS + 17;

    logic [SAMPLE_BITS-1:0] w_qtr [QTR_N+1];

    for (genvar j = 0; j <= QTR_N; j++) begin : g_qtr
        assign w_qtr[j] = quarter_entry(TB, j);
    end

    logic [TB-1:0]          w_k;
    logic [1:0]             w_quad;
    logic [IDX_W-1:0]       w_off;
    logic [IDX_W-1:0]       w_idx;
    logic [SAMPLE_BITS-1:0] w_sin_mag;
    logic                   w_neg_half;
    logic [PHASE_BITS-1:0]  w_fold;
    logic [MW-1:0]          w_saw_mag;
    logic [MW-1:0]          w_tri_a;
    logic [MW-1:0]          w_tri_b;
    logic [MW-1:0]          w_tri_mag;
    logic                   w_tri_neg;
    logic [MW-1:0]          w_saw_rnd;
    logic [MW-1:0]          w_tri_rnd;
    logic [SAMPLE_BITS-1:0] w_saw_v;
    logic [SAMPLE_BITS-1:0] w_tri_v;

    assign w_k        = i_phase[PHASE_BITS-1 -: TB];
    assign w_quad     = w_k[TB-1:TB-2];
    assign w_off      = {1'b0, w_k[TB-3:0]};
    assign w_idx      = w_quad[0] ? (IDX_W'(QTR_N) - w_off) : w_off;
    assign w_sin_mag  = w_qtr[w_idx];

    assign w_neg_half = i_phase[PHASE_BITS-1];
    assign w_fold     = w_neg_half ? (PHASE_BITS'(0) - i_phase) : i_phase;

    assign w_saw_mag  = MW'(w_fold) * MW'(2 * AMP);
    assign w_tri_a    = MW'(w_fold) * MW'(4 * AMP);
    assign w_tri_b    = MW'(AMP) << PHASE_BITS;
    assign w_tri_neg  = (w_tri_a < w_tri_b);
    assign w_tri_mag  = w_tri_neg ? (w_tri_b - w_tri_a) : (w_tri_a - w_tri_b);

    assign w_saw_rnd  = (w_saw_mag + (MW'(1) << (PHASE_BITS - 1))) >> PHASE_BITS;
    assign w_tri_rnd  = (w_tri_mag + (MW'(1) << (PHASE_BITS - 1))) >> PHASE_BITS;
    assign w_saw_v    = w_saw_rnd[SAMPLE_BITS-1:0];
    assign w_tri_v    = w_tri_rnd[SAMPLE_BITS-1:0];

    always_comb begin
        case (i_wave)
            WAVE_SINE: begin
                o_sample = w_quad[1] ? signed'(SAMPLE_BITS'(0) - w_sin_mag) : signed'(w_sin_mag);
            end
            WAVE_SAW: begin
                o_sample = w_neg_half ? signed'(SAMPLE_BITS'(0) - w_saw_v) : signed'(w_saw_v);
            end
            WAVE_TRI: begin
                o_sample = w_tri_neg ? signed'(SAMPLE_BITS'(0) - w_tri_v) : signed'(w_tri_v);
            end
            default: begin
                o_sample = w_neg_half ? signed'(SAMPLE_BITS'(0) - SAMPLE_BITS'(AMP))
                                      : signed'(SAMPLE_BITS'(AMP));
            end
        endcase
    end

endmodule

@@ design/multi_waveform_oscillator.sv @@
// Tone generator built on a phase accumulator. Each request on i_req is one
// sample tick; it carries start_req, which restarts the tone at phase zero
// and sample index zero. Every request yields exactly one result on o_smp:
// the sample of the selected waveform with active set while a tone runs and
// last set on its final sample, or a zero sample with both flags clear.
// The waveform, phase step and tone length are written through the plain
// write port i_cfg_we, i_cfg_index and i_cfg_data; the user must write them only
// while the block is idle (not enforced by the block), and they take effect on
// the next request. The result is registered and appears in the cycle after its
// request is accepted. The block takes one request per cycle while the receiver
// keeps ready high, as the single output register is refilled in the same cycle
// that its result is taken. When the receiver holds ready low, the output
// register keeps its result and i_req.ready falls until that result is taken.
// Synchronous reset clears the configuration, the phase, the sample counter
// and the running flag, and empties the output register.
module multi_waveform_oscillator #(
    parameter int SINE_TABLE_BITS = mwo_pkg::DEF_SINE_TABLE_BITS,
    parameter int PHASE_BITS      = mwo_pkg::DEF_PHASE_BITS,
    parameter int COUNT_BITS      = mwo_pkg::DEF_COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mwo_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [mwo_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    mwo_req_if.sink                             i_req,
    mwo_smp_if.source                           o_smp
);
    import mwo_pkg::*;

    localparam int LW = ((COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS) + 1;

    t_wave                   r_wave;
    logic [STEP_BITS-1:0]    r_step;
    logic [LENGTH_BITS-1:0]  r_len;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [COUNT_BITS-1:0]   r_cnt;
    logic                    r_run;
    logic                    r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                    r_active;
    logic                    r_last;

    logic [PHASE_BITS-1:0]   n_phase;
    logic [COUNT_BITS-1:0]   n_cnt;
    logic                    n_run;
    logic signed [SAMPLE_BITS-1:0] n_sample;
    logic                    n_last;

    logic                    w_accept;
    logic [LW-1:0]           w_len_x;
    logic [LW-1:0]           w_cmax;
    logic [LW-1:0]           w_len;
    logic [PHASE_BITS-1:0]   w_phase0;
    logic [COUNT_BITS-1:0]   w_cnt0;
    logic                    w_run0;
    logic signed [SAMPLE_BITS-1:0] w_wave;

    assign i_req.ready = !r_out_valid || o_smp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_len_x  = LW'(r_len);
    assign w_cmax   = LW'(1) << COUNT_BITS;
    assign w_len    = (w_len_x > w_cmax) ? w_cmax : w_len_x;
    assign w_phase0 = i_req.start_req ? '0 : r_phase;
    assign w_cnt0   = i_req.start_req ? '0 : r_cnt;
    assign w_run0   = i_req.start_req ? (w_len != '0) : r_run;

    mwo_wave #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_wave (
        .i_wave   (r_wave),
        .i_phase  (w_phase0),
        .o_sample (w_wave)
    );

    always_comb begin
        n_phase  = w_phase0;
        n_cnt    = w_cnt0;
        n_run    = w_run0;
        n_sample = '0;
        n_last   = 1'b0;
        if (w_run0) begin
            n_sample = w_wave;
            n_last   = ((LW'(w_cnt0) + LW'(1)) >= w_len);
            n_phase  = w_phase0 + PHASE_BITS'(r_step);
            n_run    = !n_last;
            if (!n_last) begin
                n_cnt = w_cnt0 + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave      <= WAVE_SINE;
            r_step      <= '0;
            r_len       <= '0;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WAVEFORM:    r_wave <= t_wave'(i_cfg_data[WAVE_BITS-1:0]);
                    CFG_PHASE_STEP:  r_step <= i_cfg_data[STEP_BITS-1:0];
                    CFG_TONE_LENGTH: r_len  <= i_cfg_data[LENGTH_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_run       <= n_run;
                r_out_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= n_sample;
            r_active <= w_run0;
            r_last   <= n_last;
        end
    end

    assign o_smp.valid  = r_out_valid;
    assign o_smp.sample = r_sample;
    assign o_smp.active = r_active;
    assign o_smp.last   = r_last;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("Accepted request produced no result.");

    a_last_is_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> r_active)
        else $error("Final sample flagged outside a running tone.");

    a_idle_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_active) |-> (r_sample == '0))
        else $error("Nonzero sample outside a running tone.");

    a_last_stops_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_last) |=> !r_run)
        else $error("Tone kept running after its final sample.");

endmodule
